// ===== rtl/dadc_pkg.sv =====
// shared types, constants and calendar tables of the date offset core
`timescale 1ns / 1ps
`default_nettype none

package dadc_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int YEAR_W = 14;
    localparam int Z_W    = 23;

    localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1902;
    localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2037;

    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] CFG_MIN_YEAR = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX_YEAR = 1'd1;

    localparam longint DAYS_PER_ERA = 146097;
    localparam int     YEAR_BIAS    = 400;

    // reciprocal multipliers, shift chosen so the quotient is exact over the input width
    localparam int     D25_SH    = 19;
    localparam longint D25_M     = ((64'd1 << D25_SH) + 64'd24) / 64'd25;
    localparam int     ERA_SH    = 41;
    localparam longint ERA_M     = ((64'd1 << ERA_SH) + DAYS_PER_ERA - 64'd1) / DAYS_PER_ERA;
    localparam int     D1460_SH  = 29;
    localparam longint D1460_M   = ((64'd1 << D1460_SH) + 64'd1459) / 64'd1460;
    localparam int     D36524_SH = 34;
    localparam longint D36524_M  = ((64'd1 << D36524_SH) + 64'd36523) / 64'd36524;
    localparam int     D365_SH   = 27;
    localparam longint D365_M    = ((64'd1 << D365_SH) + 64'd364) / 64'd365;
    localparam int     D100_SH   = 16;
    localparam longint D100_M    = ((64'd1 << D100_SH) + 64'd99) / 64'd100;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_MONTH    = 3'd1,
        ERR_DAY      = 3'd2,
        ERR_YEAR_IN  = 3'd3,
        ERR_YEAR_OUT = 3'd4
    } t_err;

    typedef struct packed {
        logic [Z_W-1:0]    z;
        t_err              err;
        logic [4:0]        day;
        logic [3:0]        month;
        logic [YEAR_W-1:0] year;
    } t_item;

    // first day of a month within a year that starts in march
    function automatic logic [8:0] mar_base(input logic [3:0] mp);
        logic [8:0] v;
        begin
            case (mp)
                4'd0:    v = 9'd0;
                4'd1:    v = 9'd31;
                4'd2:    v = 9'd61;
                4'd3:    v = 9'd92;
                4'd4:    v = 9'd122;
                4'd5:    v = 9'd153;
                4'd6:    v = 9'd184;
                4'd7:    v = 9'd214;
                4'd8:    v = 9'd245;
                4'd9:    v = 9'd275;
                4'd10:   v = 9'd306;
                4'd11:   v = 9'd337;
                default: v = 9'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] v;
        begin
            case (m)
                4'd2:                      v = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   v = 5'd30;
                default:                   v = 5'd31;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/date_add_days_checked_core.sv =====
// top level: checked gregorian date plus signed day offset
//
// input channel: i_valid / o_stall with the start date and a signed 17-bit day
// offset; a beat is taken at a rising edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall with the result date and an error code
// (0 ok, 1 bad month, 2 bad day, 3 start year out of range, 4 result year out
// of range); on an error the start date is returned unchanged.
// year limits are written through i_cfg_we / i_cfg_addr / i_cfg_data while idle;
// reset loads 1902 and 2037.
// one beat per cycle in both directions, sustained while i_stall stays low.
// o_valid rises once the beat has passed the 4 front stages, one queue slot, the
// 9 back stages and the output register; the stage count is set by the reciprocal
// multiplies and the era, year and month steps that run one per stage.
// a stalled output holds; the back pipeline stops, the 4-entry queue fills and
// then the front raises o_stall. reset empties all stages and the queue.
`timescale 1ns / 1ps
`default_nettype none

module date_add_days_checked_core #(
    parameter int QUEUE_DEPTH = dadc_pkg::QUEUE_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [dadc_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [dadc_pkg::YEAR_W-1:0]   i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [4:0]                    i_day_in,
    input  wire logic [3:0]                    i_month_in,
    input  wire logic [dadc_pkg::YEAR_W-1:0]   i_year_in,
    input  wire logic signed [16:0]            i_day_offset,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [4:0]                         o_day_out,
    output logic [3:0]                         o_month_out,
    output logic [dadc_pkg::YEAR_W-1:0]        o_year_out,
    output logic [2:0]                         o_error_code
);

    logic [dadc_pkg::YEAR_W-1:0] r_min_year;
    logic [dadc_pkg::YEAR_W-1:0] r_max_year;

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    dadc_pkg::t_item fq_item;
    dadc_pkg::t_item qb_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= dadc_pkg::MIN_YEAR_RST;
            r_max_year <= dadc_pkg::MAX_YEAR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                dadc_pkg::CFG_MIN_YEAR: r_min_year <= i_cfg_data;
                dadc_pkg::CFG_MAX_YEAR: r_max_year <= i_cfg_data;
            endcase
        end
    end

    dadc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_day_in     (i_day_in),
        .i_month_in   (i_month_in),
        .i_year_in    (i_year_in),
        .i_day_offset (i_day_offset),
        .i_min_year   (r_min_year),
        .i_max_year   (r_max_year),
        .o_push       (push),
        .o_item       (fq_item),
        .i_full       (full)
    );

    dadc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (fq_item),
        .i_pop   (pop),
        .o_item  (qb_item),
        .o_full  (full),
        .o_empty (empty)
    );

    dadc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (qb_item),
        .i_empty      (empty),
        .o_pop        (pop),
        .i_min_year   (r_min_year),
        .i_max_year   (r_max_year),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_day_out    (o_day_out),
        .o_month_out  (o_month_out),
        .o_year_out   (o_year_out),
        .o_error_code (o_error_code)
    );

endmodule

`default_nettype wire

// ===== rtl/dadc_front.sv =====
// front pipeline: date check and day count of the shifted calendar
`timescale 1ns / 1ps
`default_nettype none

module dadc_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [4:0]                    i_day_in,
    input  wire logic [3:0]                    i_month_in,
    input  wire logic [dadc_pkg::YEAR_W-1:0]   i_year_in,
    input  wire logic signed [16:0]            i_day_offset,
    input  wire logic [dadc_pkg::YEAR_W-1:0]   i_min_year,
    input  wire logic [dadc_pkg::YEAR_W-1:0]   i_max_year,
    output logic                               o_push,
    output dadc_pkg::t_item                    o_item,
    input  wire logic                          i_full
);

    typedef struct packed {
        logic [4:0]                  day;
        logic [3:0]                  month;
        logic [dadc_pkg::YEAR_W-1:0] year;
        logic [16:0]                 off;
        logic [14:0]                 ya;
        logic [9:0]                  q25y;
        logic [8:0]                  doy;
        logic                        mbad;
        dadc_pkg::t_err              err;
        logic [dadc_pkg::Z_W-1:0]    ya365;
        logic [12:0]                 ya4;
        logic [7:0]                  q100;
        logic [5:0]                  q400;
        logic [dadc_pkg::Z_W-1:0]    a;
        logic [17:0]                 b;
    } t_fstage;

    t_fstage    r_fs [1:4];
    t_fstage    n_fs [1:4];
    logic [4:1] r_fv;
    logic       en;

    logic [28:0] p25y;
    logic [28:0] p100;
    logic [28:0] p400;
    logic [3:0]  mp1;
    logic        div25;
    logic        leap;
    logic [4:0]  mlen;

    assign en      = !r_fv[4] || !i_full;
    assign o_stall = !en;
    assign o_push  = en && r_fv[4];

    always_comb begin
        n_fs[1]       = '0;
        n_fs[1].day   = i_day_in;
        n_fs[1].month = i_month_in;
        n_fs[1].year  = i_year_in;
        n_fs[1].off   = i_day_offset;

        // stage 2: shifted year, year / 25, day within the march-based year
        n_fs[2]      = r_fs[1];
        n_fs[2].ya   = 15'({1'b0, r_fs[1].year}) + 15'(dadc_pkg::YEAR_BIAS)
                       - ((r_fs[1].month <= 4'd2) ? 15'd1 : 15'd0);
        p25y         = 29'(r_fs[1].year) * 29'(dadc_pkg::D25_M);
        n_fs[2].q25y = p25y[28:19];
        mp1          = (r_fs[1].month > 4'd2) ? r_fs[1].month - 4'd3 : r_fs[1].month + 4'd9;
        n_fs[2].doy  = dadc_pkg::mar_base(mp1) + 9'(r_fs[1].day) - 9'd1;
        n_fs[2].mbad = (r_fs[1].month == 4'd0) || (r_fs[1].month > 4'd12);

        // stage 3: classification and year terms of the day count
        n_fs[3] = r_fs[2];
        div25   = (14'({4'd0, r_fs[2].q25y}) * 14'd25) == r_fs[2].year;
        leap    = (r_fs[2].year[1:0] == 2'd0) && (!div25 || (r_fs[2].year[3:0] == 4'd0));
        mlen    = dadc_pkg::month_len(r_fs[2].month, leap);
        priority if (r_fs[2].mbad) begin
            n_fs[3].err = dadc_pkg::ERR_MONTH;
        end else if (r_fs[2].day == 5'd0 || r_fs[2].day > mlen) begin
            n_fs[3].err = dadc_pkg::ERR_DAY;
        end else if (r_fs[2].year < i_min_year || r_fs[2].year > i_max_year) begin
            n_fs[3].err = dadc_pkg::ERR_YEAR_IN;
        end else begin
            n_fs[3].err = dadc_pkg::ERR_NONE;
        end
        n_fs[3].ya365 = 23'(r_fs[2].ya) * 23'd365;
        n_fs[3].ya4   = r_fs[2].ya[14:2];
        p100          = 29'(r_fs[2].ya[14:2]) * 29'(dadc_pkg::D25_M);
        n_fs[3].q100  = p100[26:19];
        p400          = 29'(r_fs[2].ya[14:4]) * 29'(dadc_pkg::D25_M);
        n_fs[3].q400  = p400[24:19];

        // stage 4: partial sums
        n_fs[4]   = r_fs[3];
        n_fs[4].a = r_fs[3].ya365 + 23'(r_fs[3].ya4) - 23'(r_fs[3].q100);
        n_fs[4].b = {r_fs[3].off[16], r_fs[3].off} + 18'(r_fs[3].q400) + 18'(r_fs[3].doy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (en) begin
            r_fv <= {r_fv[3:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fs[1] <= n_fs[1];
            r_fs[2] <= n_fs[2];
            r_fs[3] <= n_fs[3];
            r_fs[4] <= n_fs[4];
        end
    end

    always_comb begin
        o_item       = '0;
        o_item.z     = r_fs[4].a + {{5{r_fs[4].b[17]}}, r_fs[4].b};
        o_item.err   = r_fs[4].err;
        o_item.day   = r_fs[4].day;
        o_item.month = r_fs[4].month;
        o_item.year  = r_fs[4].year;
    end

endmodule

`default_nettype wire

// ===== rtl/dadc_queue.sv =====
// small register queue between the front and back pipelines
`timescale 1ns / 1ps
`default_nettype none

module dadc_queue #(
    parameter int DEPTH = dadc_pkg::QUEUE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire dadc_pkg::t_item i_item,
    input  wire logic      i_pop,
    output dadc_pkg::t_item o_item,
    output logic           o_full,
    output logic           o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dadc_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;
    logic            do_push;
    logic            do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];
    assign n_wr    = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dadc_back.sv =====
// back pipeline: day count back to a calendar date, result year check, output register
`timescale 1ns / 1ps
`default_nettype none

module dadc_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dadc_pkg::t_item               i_item,
    input  wire logic                          i_empty,
    output logic                               o_pop,
    input  wire logic [dadc_pkg::YEAR_W-1:0]   i_min_year,
    input  wire logic [dadc_pkg::YEAR_W-1:0]   i_max_year,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [4:0]                         o_day_out,
    output logic [3:0]                         o_month_out,
    output logic [dadc_pkg::YEAR_W-1:0]        o_year_out,
    output logic [2:0]                         o_error_code
);

    typedef struct packed {
        dadc_pkg::t_item it;
        logic [5:0]      era;
        logic [17:0]     doe;
        logic [7:0]      q1460;
        logic [2:0]      q36524;
        logic            f;
        logic [17:0]     t;
        logic [8:0]      yoe;
        logic [16:0]     y365;
        logic [2:0]      yq100;
        logic [8:0]      doy;
        logic [4:0]      rd;
        logic [3:0]      rm;
        logic [15:0]     ry;
    } t_bstage;

    t_bstage    r_bs [1:9];
    t_bstage    n_bs [1:9];
    logic [9:1] r_bv;
    logic       r_ov;
    logic       en;

    logic [4:0]                  r_day;
    logic [3:0]                  r_month;
    logic [dadc_pkg::YEAR_W-1:0] r_year;
    dadc_pkg::t_err              r_err;

    logic [46:0]                 pera;
    logic [dadc_pkg::Z_W-1:0]    pdays;
    logic [36:0]                 p1460;
    logic [36:0]                 p36524;
    logic [36:0]                 p365;
    logic [18:0]                 p100;
    logic [17:0]                 ysum;
    logic [3:0]                  mp;

    dadc_pkg::t_err              n_err;
    logic signed [15:0]          ry_s;

    assign en      = !r_ov || !i_stall;
    assign o_pop   = en && !i_empty;
    assign o_valid = r_ov;

    always_comb begin
        n_bs[1]    = '0;
        n_bs[1].it = i_item;

        n_bs[2]     = r_bs[1];
        pera        = 47'(r_bs[1].it.z) * 47'(dadc_pkg::ERA_M);
        n_bs[2].era = pera[46:41];

        n_bs[3]     = r_bs[2];
        pdays       = 23'(r_bs[2].era) * 23'(dadc_pkg::DAYS_PER_ERA);
        n_bs[3].doe = 18'(r_bs[2].it.z - pdays);

        n_bs[4]        = r_bs[3];
        p1460          = 37'(r_bs[3].doe) * 37'(dadc_pkg::D1460_M);
        n_bs[4].q1460  = p1460[36:29];
        p36524         = 37'(r_bs[3].doe) * 37'(dadc_pkg::D36524_M);
        n_bs[4].q36524 = p36524[36:34];
        n_bs[4].f      = r_bs[3].doe == 18'(dadc_pkg::DAYS_PER_ERA - 1);

        n_bs[5]   = r_bs[4];
        n_bs[5].t = r_bs[4].doe - 18'(r_bs[4].q1460) + 18'(r_bs[4].q36524) - 18'(r_bs[4].f);

        n_bs[6]     = r_bs[5];
        p365        = 37'(r_bs[5].t) * 37'(dadc_pkg::D365_M);
        n_bs[6].yoe = p365[35:27];

        n_bs[7]       = r_bs[6];
        n_bs[7].y365  = 17'(r_bs[6].yoe) * 17'd365;
        p100          = 19'(r_bs[6].yoe) * 19'(dadc_pkg::D100_M);
        n_bs[7].yq100 = p100[18:16];

        n_bs[8]     = r_bs[7];
        ysum        = 18'(r_bs[7].y365) + 18'(r_bs[7].yoe[8:2]) - 18'(r_bs[7].yq100);
        n_bs[8].doy = 9'(r_bs[7].doe - ysum);

        // month search over the march-based table
        n_bs[9] = r_bs[8];
        mp      = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (r_bs[8].doy >= dadc_pkg::mar_base(4'(i))) begin
                mp = 4'(i);
            end
        end
        n_bs[9].rd = 5'(r_bs[8].doy - dadc_pkg::mar_base(mp) + 9'd1);
        n_bs[9].rm = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
        n_bs[9].ry = 16'(r_bs[8].yoe) + 16'(r_bs[8].era) * 16'd400
                     + ((mp >= 4'd10) ? 16'd1 : 16'd0) - 16'(dadc_pkg::YEAR_BIAS);
    end

    always_comb begin
        ry_s  = $signed(r_bs[9].ry);
        n_err = r_bs[9].it.err;
        if (n_err == dadc_pkg::ERR_NONE
            && (ry_s < $signed({2'b00, i_min_year}) || ry_s > $signed({2'b00, i_max_year}))) begin
            n_err = dadc_pkg::ERR_YEAR_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_bv <= {r_bv[8:1], !i_empty};
            r_ov <= r_bv[9];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 1; k <= 9; k++) begin
                r_bs[k] <= n_bs[k];
            end
            r_err <= n_err;
            if (n_err == dadc_pkg::ERR_NONE) begin
                r_day   <= r_bs[9].rd;
                r_month <= r_bs[9].rm;
                r_year  <= r_bs[9].ry[dadc_pkg::YEAR_W-1:0];
            end else begin
                r_day   <= r_bs[9].it.day;
                r_month <= r_bs[9].it.month;
                r_year  <= r_bs[9].it.year;
            end
        end
    end

    assign o_day_out    = r_day;
    assign o_month_out  = r_month;
    assign o_year_out   = r_year;
    assign o_error_code = r_err;

endmodule

`default_nettype wire
